/* src/k_way_sorted_merge_unit_macros.svh */
// Assertion macros for the k-way sorted merge unit.
// Needs signals named clk and rst_n in the including module.
`ifndef K_WAY_SORTED_MERGE_UNIT_MACROS_SVH
`define K_WAY_SORTED_MERGE_UNIT_MACROS_SVH

// check a property at every rising clock edge out of reset
`define KWSM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("kwsm assertion failed");

// check that a condition in one cycle implies another in the next
`define KWSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kwsm assertion failed");

`endif

/* src/kwsm_pkg.sv */
// Package for the k-way sorted merge unit: sizes, entry and control types,
// and the order compare. No dependencies.
`default_nettype none

package kwsm_pkg;

    localparam int LANES   = 16;
    localparam int VALUE_W = 32;
    localparam int LANE_W  = 4;
    localparam int CNT_W   = $clog2(LANES + 1);
    localparam int CFG_W   = 5;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [LANE_W-1:0]         lane;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } chain_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    function automatic logic key_less(input entry_t a, input entry_t b);
        logic lt_v;
        logic eq_v;
        lt_v = $signed(a.value) < $signed(b.value);
        eq_v = a.value == b.value;
        return lt_v || (eq_v && (a.lane < b.lane));
    endfunction

endpackage

`default_nettype wire

/* src/kwsm_cell.sv */
// One cell of the sorted chain: holds one entry, shifts it left on a pop
// and makes room for an insert. Depends on kwsm_pkg.
`default_nettype none

module kwsm_cell (
    input  logic                 clk,
    input  kwsm_pkg::chain_ctrl_t ctrl,
    input  kwsm_pkg::entry_t     new_entry,
    input  logic                 occ,
    input  kwsm_pkg::entry_t     left_entry,
    input  logic                 left_lt,
    input  kwsm_pkg::entry_t     right_entry,
    output kwsm_pkg::entry_t     entry,
    output logic                 lt
);
    import kwsm_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    assign lt    = !occ || key_less(new_entry, entry_reg);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.insert && lt)
        begin
            entry_next = left_lt ? left_entry : new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

/* src/kwsm_chain.sv */
// Row of kwsm_cell instances kept in ascending order, smallest at cell 0.
// Depends on kwsm_pkg and kwsm_cell.
`default_nettype none

module kwsm_chain (
    input  logic                   clk,
    input  kwsm_pkg::chain_ctrl_t  ctrl,
    input  kwsm_pkg::entry_t       new_entry,
    input  logic [kwsm_pkg::CNT_W-1:0] cnt,
    output kwsm_pkg::entry_t       head,
    output kwsm_pkg::entry_t       second
);
    import kwsm_pkg::*;

    entry_t entries [LANES];
    logic   lts     [LANES];

    genvar i;
    generate
        for (i = 0; i < LANES; i++)
        begin : g_cell
            entry_t left_e;
            logic   left_l;
            entry_t right_e;
            logic   occ_i;

            assign occ_i = CNT_W'(i) < cnt;

            if (i == 0)
            begin : g_first
                assign left_e = new_entry;
                assign left_l = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = entries[i-1];
                assign left_l = lts[i-1];
            end

            if (i == LANES - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_body
                assign right_e = entries[i+1];
            end

            kwsm_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .occ         (occ_i),
                .left_entry  (left_e),
                .left_lt     (left_l),
                .right_entry (right_e),
                .entry       (entries[i]),
                .lt          (lts[i])
            );
        end
    endgenerate

    assign head   = entries[0];
    assign second = entries[1];

endmodule

`default_nettype wire

/* src/k_way_sorted_merge_unit.sv */
// Top level of the k-way sorted merge unit: load/merge control, output
// register and the sorted cell chain. Depends on kwsm_pkg, kwsm_chain and the macros header.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------
//  input    | in_valid / in_ready | lane, value, lane_empty
//  output   | out_valid/out_ready | merged_value, source_lane, has_value,
//           |                     | done_res, status
//  config   | cfg_we              | cfg_wdata (lanes_in_use)
//
// An item that yields a result is accepted and inserted into the chain, then
// the emit state pops the chain head into the output register or writes done
// or an error status. A load item yielding no result skips the emit state,
// which waits while the output register is full and not taken. Reset clears
// control state only; chain entries past the held count are never read.
`default_nettype none

module k_way_sorted_merge_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [kwsm_pkg::LANE_W-1:0]   lane,
    input  logic signed [kwsm_pkg::VALUE_W-1:0] value,
    input  logic                          lane_empty,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [kwsm_pkg::VALUE_W-1:0] merged_value,
    output logic [kwsm_pkg::LANE_W-1:0]   source_lane,
    output logic                          has_value,
    output logic                          done_res,
    output logic                          status,
    input  logic                          cfg_we,
    input  logic [kwsm_pkg::CFG_W-1:0]    cfg_wdata
);
    import kwsm_pkg::*;

    `include "k_way_sorted_merge_unit_macros.svh"

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  reported_reg, reported_next;
    logic              merging_reg, merging_next;
    logic [LANE_W-1:0] awaited_reg, awaited_next;
    logic              finished_reg, finished_next;
    logic [CFG_W-1:0]  lanes_reg, lanes_next;
    logic              err_reg, err_next;
    logic              out_valid_reg, out_valid_next;

    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [LANE_W-1:0]  src_reg, src_next;
    logic               has_reg, has_next;
    logic               done_reg, done_next;
    logic               status_reg, status_next;

    chain_ctrl_t       ctrl;
    entry_t            new_entry;
    entry_t            head;
    entry_t            second;
    logic [CNT_W-1:0]  eff_lanes;
    logic [CNT_W-1:0]  reported_inc;
    logic              accept;
    logic              wrong;
    logic              out_free;

    assign in_ready        = state_reg == S_IDLE;
    assign accept          = in_valid && in_ready;
    assign wrong           = finished_reg || (lane != awaited_reg);
    assign out_free        = !out_valid_reg || out_ready;
    assign new_entry.value = value;
    assign new_entry.lane  = lane;
    assign reported_inc    = reported_reg + CNT_W'(1);

    always_comb
    begin
        priority if (lanes_reg == '0)
            eff_lanes = CNT_W'(1);
        else if (CNT_W'(lanes_reg) > CNT_W'(LANES))
            eff_lanes = CNT_W'(LANES);
        else
            eff_lanes = CNT_W'(lanes_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        reported_next  = reported_reg;
        merging_next   = merging_reg;
        awaited_next   = awaited_reg;
        finished_next  = finished_reg;
        lanes_next     = cfg_we ? cfg_wdata : lanes_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        src_next       = src_reg;
        has_next       = has_reg;
        done_next      = done_reg;
        status_next    = status_reg;
        ctrl           = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (wrong)
                    begin
                        err_next   = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        err_next = 1'b0;
                        if (!lane_empty && (cnt_reg < CNT_W'(LANES)))
                        begin
                            ctrl.insert = 1'b1;
                            cnt_next    = cnt_reg + CNT_W'(1);
                        end
                        if (!merging_reg)
                        begin
                            reported_next = reported_inc;
                            awaited_next  = awaited_reg + LANE_W'(1);
                            if (reported_inc >= eff_lanes)
                            begin
                                merging_next = 1'b1;
                                state_next   = S_EMIT;
                            end
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = '0;
                    src_next       = '0;
                    has_next       = 1'b0;
                    done_next      = 1'b0;
                    status_next    = 1'b0;
                    priority if (err_reg)
                    begin
                        status_next = 1'b1;
                    end
                    else if (cnt_reg == '0)
                    begin
                        done_next     = 1'b1;
                        finished_next = 1'b1;
                    end
                    else
                    begin
                        value_next   = head.value;
                        src_next     = head.lane;
                        has_next     = 1'b1;
                        awaited_next = head.lane;
                        ctrl.pop     = 1'b1;
                        cnt_next     = cnt_reg - CNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            reported_reg  <= '0;
            merging_reg   <= 1'b0;
            awaited_reg   <= '0;
            finished_reg  <= 1'b0;
            lanes_reg     <= CFG_W'(LANES);
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            reported_reg  <= reported_next;
            merging_reg   <= merging_next;
            awaited_reg   <= awaited_next;
            finished_reg  <= finished_next;
            lanes_reg     <= lanes_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        src_reg    <= src_next;
        has_reg    <= has_next;
        done_reg   <= done_next;
        status_reg <= status_next;
    end

    kwsm_chain u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .new_entry (new_entry),
        .cnt       (cnt_reg),
        .head      (head),
        .second    (second)
    );

    assign out_valid    = out_valid_reg;
    assign merged_value = value_reg;
    assign source_lane  = src_reg;
    assign has_value    = has_reg;
    assign done_res     = done_reg;
    assign status       = status_reg;

    `KWSM_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(LANES))
    `KWSM_ASSERT(a_finished_err_only, (state_reg == S_EMIT && finished_reg) |-> err_reg)
    `KWSM_ASSERT(a_head_order, (cnt_reg >= CNT_W'(2)) |-> !key_less(second, head))
    `KWSM_ASSERT_NEXT(a_pop_count, ctrl.pop, cnt_reg == $past(cnt_reg) - CNT_W'(1))

endmodule

`default_nettype wire
